// ===== hw/rtl/lohc_pkg.sv =====
// Shared types and codes for the LRU open handle cache.
`default_nettype none
package lohc_pkg;

    // Widths fixed by the item format
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int CFG_W    = 5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EVICTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd4;

    // Input action codes
    localparam logic ACT_ACCESS    = 1'b0;
    localparam logic ACT_TERMINATE = 1'b1;

    // Reset value of the open limit
    localparam logic [CFG_W-1:0] MAX_OPEN_RST = 5'd16;

    // Update broadcast to the cell row
    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    // Search flags reported by each cell
    typedef struct packed {
        logic hit;
        logic first_free;
        logic oldest;
    } cell_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lohc_cell.sv =====
// One table entry: key, valid bit and recency age, with its own compare and update.
`default_nettype none
module lohc_cell #(
    parameter int AW = 4
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire [lohc_pkg::KEY_W-1:0] cmd_key,
    input  wire [AW-1:0]              oldest_age,
    input  lohc_pkg::op_t             op,
    input  wire                       sel,
    input  wire [AW-1:0]              ref_age,
    input  wire                       free_seen_in,
    output logic                      free_seen_out,
    output lohc_pkg::cell_flags_t     flags,
    output logic [lohc_pkg::KEY_W-1:0] key_q,
    output logic [AW-1:0]             age_q
);
    import lohc_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             valid_reg, valid_next;
    logic [AW-1:0]    age_reg, age_next;

    // Search: compare, lowest free slot along the row, oldest entry
    always_comb begin
        flags.hit        = valid_reg && (key_reg == cmd_key);
        flags.first_free = !valid_reg && !free_seen_in;
        flags.oldest     = valid_reg && (age_reg == oldest_age);
        free_seen_out    = free_seen_in || !valid_reg;
        key_q            = key_reg;
        age_q            = age_reg;
    end

    // Update on the broadcast operation
    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        age_next   = age_reg;
        case (op)
            OP_TOUCH: begin
                if (sel) begin
                    key_next = cmd_key;
                    age_next = '0;
                end else if (valid_reg && (age_reg < ref_age)) begin
                    age_next = age_reg + AW'(1);
                end
            end
            OP_INSERT: begin
                if (sel) begin
                    key_next   = cmd_key;
                    valid_next = 1'b1;
                    age_next   = '0;
                end else if (valid_reg) begin
                    age_next = age_reg + AW'(1);
                end
            end
            OP_REMOVE: begin
                if (sel) begin
                    valid_next = 1'b0;
                    age_next   = '0;
                end else if (valid_reg && (age_reg > ref_age)) begin
                    age_next = age_reg - AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // Key holds no reset; it is never used while invalid
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lru_open_handle_cache.sv =====
// Command registered on input transfer, decision in search state, result in update state,
// which holds while m_* has an unaccepted result. Items pass the accept/search/update
// sequencer over the cell row one at a time; the next is taken while a result waits on m_*.
// Reset (aresetn low, synchronous): all entries invalid, ages and count zero,
// max_open back to 16, output empty. Keys are not cleared.
`default_nettype none
module lru_open_handle_cache #(
    parameter int CAPACITY = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration: max_open
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] flow_key
    input  wire  [0:0]  s_tuser,   // [0] action
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [3:0] slot, [35:4] evicted_key, [39:36] zero
    output logic [2:0]  m_tuser    // [2:0] status
);
    import lohc_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = AW;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    // Sequencer
    state_t state_reg, state_next;
    logic   search_en, upd_go;

    // Registered command
    logic             act_reg;
    logic [KEY_W-1:0] key_reg;

    // Configuration and occupancy
    logic [CFG_W-1:0] max_open_reg;
    logic [CW-1:0]    count_reg, count_next;

    // Decision taken in search, applied in update
    op_t                 pend_op_reg, pend_op_next;
    logic [CAPACITY-1:0] pend_sel_reg, pend_sel_next;
    logic [AW-1:0]       pend_age_reg, pend_age_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [SW-1:0]       pend_slot_reg, pend_slot_next;
    logic [KEY_W-1:0]    pend_ek_reg, pend_ek_next;

    // Output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [KEY_W-1:0]    m_ek_reg;

    // Cell row
    cell_flags_t         flags [CAPACITY];
    logic [KEY_W-1:0]    cell_key [CAPACITY];
    logic [AW-1:0]       cell_age [CAPACITY];
    logic [CAPACITY:0]   free_chain;
    logic [AW-1:0]       oldest_age;
    op_t                 cell_op;

    assign free_chain[0] = 1'b0;
    assign oldest_age    = AW'(count_reg - CW'(1));
    assign cell_op       = upd_go ? pend_op_reg : OP_NONE;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lohc_cell #(.AW(AW)) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd_key       (key_reg),
            .oldest_age    (oldest_age),
            .op            (cell_op),
            .sel           (pend_sel_reg[g]),
            .ref_age       (pend_age_reg),
            .free_seen_in  (free_chain[g]),
            .free_seen_out (free_chain[g+1]),
            .flags         (flags[g]),
            .key_q         (cell_key[g]),
            .age_q         (cell_age[g])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SEARCH;
            ST_SEARCH: state_next = ST_UPDATE;
            ST_UPDATE: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        search_en = 1'b0;
        upd_go    = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_SEARCH: search_en = 1'b1;
            ST_UPDATE: upd_go    = !m_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // Search decision: encode cell flags, pick operation
    always_comb begin
        logic [CAPACITY-1:0] hit_vec, free_vec, old_vec;
        logic [SW-1:0]       hit_idx, free_idx, old_idx;
        logic [AW-1:0]       hit_age;
        logic [KEY_W-1:0]    old_key;
        logic [LW-1:0]       mo_l, limit_l;
        logic                hit_any;

        hit_idx = '0;
        free_idx = '0;
        old_idx = '0;
        hit_age = '0;
        old_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_vec[i]  = flags[i].hit;
            free_vec[i] = flags[i].first_free;
            old_vec[i]  = flags[i].oldest;
            if (flags[i].hit) begin
                hit_idx = hit_idx | SW'(i);
                hit_age = hit_age | cell_age[i];
            end
            if (flags[i].first_free) free_idx = free_idx | SW'(i);
            if (flags[i].oldest) begin
                old_idx = old_idx | SW'(i);
                old_key = old_key | cell_key[i];
            end
        end
        hit_any = |hit_vec;

        // Limit in force: max_open clamped to 1..CAPACITY
        mo_l = LW'(max_open_reg);
        if (mo_l == '0) begin
            limit_l = LW'(1);
        end else if (mo_l > LW'(CAPACITY)) begin
            limit_l = LW'(CAPACITY);
        end else begin
            limit_l = mo_l;
        end

        pend_op_next     = pend_op_reg;
        pend_sel_next    = pend_sel_reg;
        pend_age_next    = pend_age_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_ek_next     = pend_ek_reg;
        if (search_en) begin
            pend_ek_next = '0;
            if (act_reg == ACT_TERMINATE) begin
                if (hit_any) begin
                    pend_op_next     = OP_REMOVE;
                    pend_sel_next    = hit_vec;
                    pend_age_next    = hit_age;
                    pend_status_next = STAT_REMOVED;
                    pend_slot_next   = hit_idx;
                end else begin
                    pend_op_next     = OP_NONE;
                    pend_sel_next    = '0;
                    pend_age_next    = '0;
                    pend_status_next = STAT_ABSENT;
                    pend_slot_next   = '0;
                end
            end else if (hit_any) begin
                pend_op_next     = OP_TOUCH;
                pend_sel_next    = hit_vec;
                pend_age_next    = hit_age;
                pend_status_next = STAT_HIT;
                pend_slot_next   = hit_idx;
            end else if (LW'(count_reg) < limit_l) begin
                pend_op_next     = OP_INSERT;
                pend_sel_next    = free_vec;
                pend_age_next    = '0;
                pend_status_next = STAT_INSERTED;
                pend_slot_next   = free_idx;
            end else begin
                // Evict the oldest entry and reuse its slot
                pend_op_next     = OP_TOUCH;
                pend_sel_next    = old_vec;
                pend_age_next    = oldest_age;
                pend_status_next = STAT_EVICTED;
                pend_slot_next   = old_idx;
                pend_ek_next     = old_key;
            end
        end
    end

    // Occupancy count
    always_comb begin
        count_next = count_reg;
        if (upd_go) begin
            case (pend_op_reg)
                OP_INSERT: count_next = count_reg + CW'(1);
                OP_REMOVE: if (count_reg != '0) count_next = count_reg - CW'(1);
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            max_open_reg <= MAX_OPEN_RST;
            m_valid_reg  <= 1'b0;
            pend_op_reg  <= OP_NONE;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_op_reg <= pend_op_next;
            if (cfg_valid) max_open_reg <= cfg_data;
            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= s_tuser[0];
            key_reg <= s_tdata;
        end
        pend_sel_reg    <= pend_sel_next;
        pend_age_reg    <= pend_age_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_ek_reg     <= pend_ek_next;
        if (upd_go) begin
            m_status_reg <= pend_status_reg;
            m_slot_reg   <= SLOT_W'({{SLOT_W{1'b0}}, pend_slot_reg});
            m_ek_reg     <= pend_ek_reg;
        end
    end

    // Ports
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {4'b0000, m_ek_reg, m_slot_reg};

endmodule
`default_nettype wire
